// ===== rtl/trpq_pkg.sv =====
// shared types and constants for the timed release priority queue
`timescale 1ns / 1ps
`default_nettype none
package trpq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W = 48;
  localparam int ID_W = 64;
  localparam int PEN_W = 32;
  localparam int ENTRY_W = TIME_W + ID_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_PENALTY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PENALTY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_ENABLE = 2'd2;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] KIND_ENQUEUED = 2'd0;
  localparam logic [1:0] KIND_FULL = 2'd1;
  localparam logic [1:0] KIND_RELEASED = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic operation;
    logic [TIME_W-1:0] now;
    logic [ID_W-1:0] txn_ident;
    logic [5:0] abort_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [ID_W-1:0] txn_out;
    logic [PEN_W-1:0] delay;
    logic last;
  } out_item_t;

  // request from the sequencer to the delay unit and its answer
  typedef struct packed {
    logic start;
    logic [5:0] count;
  } dly_req_t;

  typedef struct packed {
    logic done;
    logic [PEN_W-1:0] delay;
  } dly_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/trpq_ram.sv =====
// generic ram with one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module trpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/trpq_delay.sv =====
// iterative backoff delay unit: one doubling and cap compare per cycle
`timescale 1ns / 1ps
`default_nettype none
module trpq_delay (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [trpq_pkg::PEN_W-1:0] base_penalty,
  input  wire logic [trpq_pkg::PEN_W-1:0] max_penalty,
  input  wire logic                      backoff_enable,
  input  wire trpq_pkg::dly_req_t        req,
  output trpq_pkg::dly_rsp_t             rsp
);

  logic                       busy;
  logic [5:0]                 remain;
  logic [trpq_pkg::PEN_W:0]   acc;
  logic [trpq_pkg::PEN_W:0]   doubled;
  logic                       capped;

  assign doubled = {acc[trpq_pkg::PEN_W-1:0], 1'b0};
  // once the value passes the cap, further doubling cannot bring it back
  assign capped = acc > {1'b0, max_penalty};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        if (!backoff_enable) begin
          rsp.done <= 1'b1;
          rsp.delay <= base_penalty;
        end else begin
          busy <= 1'b1;
          acc <= {1'b0, base_penalty};
          remain <= req.count;
        end
      end else if (busy) begin
        if (capped) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.delay <= max_penalty;
        end else if (remain == 6'd0 || acc == '0) begin
          // a zero base stays zero for any count
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.delay <= acc[trpq_pkg::PEN_W-1:0];
        end else begin
          acc <= doubled;
          remain <= remain - 6'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/timed_release_priority_queue.sv =====
// top level: sorted delay queue with sequencer, ram and delay unit
//
// Input channel (in_valid/in_ready, in_data) takes one beat per operation.
// An enqueue computes the backoff delay in the delay unit, then does a
// sorted insert by moving entries up one slot, each read and then written
// back through the entry ram, and gives one result beat with the applied
// delay, or a full beat if the queue holds QUEUE_DEPTH entries. A release
// walks the entries from the head, reading and comparing each, and gives
// one beat per expired entry (last on the final one) or one nothing
// released beat; each expired id is held back one step so that the final
// beat can carry last. The surviving entries are then moved down, each
// read and then written back. in_ready is low while an item is in work.
// Output channel (out_valid/out_ready, out_data) holds its beat in a register
// and the sequencer waits while the receiver stalls.
// Configuration writes (cfg_we, cfg_index, cfg_data) land at once; write them
// only while no item is in work. Reset empties the queue and restores
// the register defaults; the entry ram itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module timed_release_priority_queue (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire trpq_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output trpq_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_we,
  input  wire logic [trpq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [trpq_pkg::PEN_W-1:0]       cfg_data
);

  localparam int IW = trpq_pkg::IDX_W;
  localparam int CW = trpq_pkg::CNT_W;
  localparam int TW = trpq_pkg::TIME_W;
  localparam int EW = trpq_pkg::ENTRY_W;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DELAY  = 9'b000000010,
    ST_INSRD  = 9'b000000100,
    ST_INSCMP = 9'b000001000,
    ST_OUT    = 9'b000010000,
    ST_RELRD  = 9'b000100000,
    ST_RELCMP = 9'b001000000,
    ST_SHRD   = 9'b010000000,
    ST_SHWR   = 9'b100000000
  } state_t;

  state_t state;

  logic [trpq_pkg::PEN_W-1:0] base_penalty;
  logic [trpq_pkg::PEN_W-1:0] max_penalty;
  logic                       backoff_enable;

  logic [CW-1:0] occupancy;
  logic [CW-1:0] pos;
  logic [CW-1:0] nrel;
  logic [TW-1:0] now;
  logic [TW-1:0] when;
  logic [trpq_pkg::ID_W-1:0] txn;
  logic [trpq_pkg::PEN_W-1:0] dly;

  logic          we;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rdata;
  logic [TW-1:0] rtime;
  logic [TW:0]   when_sum;

  trpq_pkg::dly_req_t dreq;
  trpq_pkg::dly_rsp_t drsp;

  assign rtime = rdata[EW-1 -: TW];
  assign when_sum = {1'b0, now} + {{(TW - trpq_pkg::PEN_W + 1){1'b0}}, drsp.delay};
  assign in_ready = (state == ST_IDLE) && !out_valid;

  trpq_ram #(.WIDTH(EW), .DEPTH(trpq_pkg::QUEUE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  trpq_delay u_delay (
    .clk(clk), .rst(rst), .base_penalty(base_penalty), .max_penalty(max_penalty),
    .backoff_enable(backoff_enable), .req(dreq), .rsp(drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_penalty <= '0;
      max_penalty <= '1;
      backoff_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        trpq_pkg::REG_BASE_PENALTY: base_penalty <= cfg_data;
        trpq_pkg::REG_MAX_PENALTY: max_penalty <= cfg_data;
        trpq_pkg::REG_BACKOFF_ENABLE: backoff_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ram address and write strobes follow from the state and the position registers
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = rdata;
    raddr = '0;
    dreq.start = 1'b0;
    dreq.count = in_data.abort_count;
    case (state)
      ST_IDLE: begin
        dreq.start = in_valid && in_ready && (in_data.operation == trpq_pkg::OP_ENQUEUE)
                     && (occupancy != CW'(trpq_pkg::QUEUE_DEPTH));
      end
      ST_INSRD: raddr = IW'(pos - CW'(1));
      ST_INSCMP: begin
        we = 1'b1;
        if (pos != '0 && rtime > when) begin
          waddr = pos[IW-1:0];
          wdata = rdata;
        end else begin
          waddr = pos[IW-1:0];
          wdata = {when, txn};
        end
      end
      ST_RELRD: raddr = pos[IW-1:0];
      // keep the read data steady while the output stalls
      ST_RELCMP: raddr = pos[IW-1:0];
      ST_SHRD: raddr = IW'(pos + nrel);
      ST_SHWR: begin
        we = 1'b1;
        waddr = pos[IW-1:0];
        wdata = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            now <= in_data.now;
            txn <= in_data.txn_ident;
            pos <= '0;
            nrel <= '0;
            if (in_data.operation == trpq_pkg::OP_RELEASE) begin
              state <= ST_RELRD;
            end else if (occupancy == CW'(trpq_pkg::QUEUE_DEPTH)) begin
              out_valid <= 1'b1;
              out_data <= '{kind: trpq_pkg::KIND_FULL, txn_out: '0, delay: '0, last: 1'b1};
            end else begin
              state <= ST_DELAY;
            end
          end
        end
        ST_DELAY: begin
          if (drsp.done) begin
            dly <= drsp.delay;
            when <= when_sum[TW] ? '1 : when_sum[TW-1:0];
            pos <= occupancy;
            state <= (occupancy == '0) ? ST_INSCMP : ST_INSRD;
          end
        end
        ST_INSRD: state <= ST_INSCMP;
        ST_INSCMP: begin
          if (pos != '0 && rtime > when) begin
            pos <= pos - CW'(1);
            state <= (pos == CW'(1)) ? ST_INSCMP : ST_INSRD;
          end else begin
            occupancy <= occupancy + CW'(1);
            out_valid <= 1'b1;
            out_data <= '{kind: trpq_pkg::KIND_ENQUEUED, txn_out: '0, delay: dly, last: 1'b1};
            state <= ST_IDLE;
          end
        end
        ST_RELRD: begin
          if (pos == occupancy) begin
            state <= ST_OUT;
          end else begin
            state <= ST_RELCMP;
          end
        end
        ST_RELCMP: begin
          if (rtime < now) begin
            // the held id goes out now, the new one waits in txn
            if (nrel == '0 || !out_valid || out_ready) begin
              if (nrel != '0) begin
                out_valid <= 1'b1;
                out_data <= '{kind: trpq_pkg::KIND_RELEASED, txn_out: txn, delay: '0,
                              last: 1'b0};
              end
              txn <= rdata[trpq_pkg::ID_W-1:0];
              nrel <= nrel + CW'(1);
              pos <= pos + CW'(1);
              state <= ST_RELRD;
            end
          end else begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          // close the walk: nothing released beat, or last beat and then compact
          if (!out_valid || out_ready) begin
            if (nrel == '0) begin
              out_valid <= 1'b1;
              out_data <= '{kind: trpq_pkg::KIND_NONE, txn_out: '0, delay: '0, last: 1'b1};
              state <= ST_IDLE;
            end else begin
              out_valid <= 1'b1;
              out_data <= '{kind: trpq_pkg::KIND_RELEASED, txn_out: txn, delay: '0,
                            last: 1'b1};
              pos <= '0;
              occupancy <= occupancy - nrel;
              state <= ST_SHRD;
            end
          end
        end
        ST_SHRD: begin
          if (pos == occupancy) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_SHWR;
          end
        end
        ST_SHWR: begin
          pos <= pos + CW'(1);
          state <= ST_SHRD;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/trpq_checker.sv =====
// port level checks for the timed release priority queue
`timescale 1ns / 1ps
`default_nettype none
module trpq_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire trpq_pkg::out_item_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_not_ready_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second item back to back");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == trpq_pkg::KIND_ENQUEUED ||
                  out_data.kind == trpq_pkg::KIND_FULL ||
                  out_data.kind == trpq_pkg::KIND_NONE) |-> out_data.last)
    else $error("single result beat without last");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != trpq_pkg::KIND_ENQUEUED |-> out_data.delay == '0)
    else $error("delay set outside enqueue result");

endmodule

bind timed_release_priority_queue trpq_checker u_trpq_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
